// File: src/ppp_pkg.sv
// Shared constants and types for the pinhole point projection pipeline.
// No dependencies.
package ppp_pkg;

    // Coordinate and rotation formats
    localparam int CW     = 32;          // coordinate width, Q16.16
    localparam int RW     = 21;          // rotation entry width, Q2.19
    localparam int RFRAC  = RW - 2;      // rotation fraction bits
    localparam int PW     = RW + CW;     // one rotation product
    localparam int SW     = PW + 2;      // sum of three products
    localparam int CAMW   = SW - RFRAC + 1;  // camera coordinate after +T
    localparam int HALFM  = 18;          // split point of the focal multiply
    localparam int NUMW   = CW + CAMW;   // |f * c|
    localparam int QB     = 34;          // quotient bits before saturation
    localparam int DW     = CAMW + 1;    // divisor 2*|zc|
    localparam int NW     = NUMW + 2;    // dividend 2*|f*c| + |zc|
    localparam int TOPW   = NW - QB;     // dividend bits above the quotient
    localparam int NSTAGE = 7 + QB + 1;  // register stages, input to output

    // Register indexes
    localparam logic [2:0] REG_ROT0  = 3'd0;
    localparam logic [2:0] REG_ROT1  = 3'd1;
    localparam logic [2:0] REG_ROT2  = 3'd2;
    localparam logic [2:0] REG_TX    = 3'd3;
    localparam logic [2:0] REG_TY    = 3'd4;
    localparam logic [2:0] REG_TZ    = 3'd5;
    localparam logic [2:0] REG_FOCAL = 3'd6;
    localparam logic [2:0] REG_CTR   = 3'd7;

    localparam logic [62:0] ROT0_RST = 63'd1 << RFRAC;
    localparam logic [62:0] ROT1_RST = 63'd1 << (RFRAC + RW);
    localparam logic [62:0] ROT2_RST = 63'd1 << (RFRAC + 2 * RW);
    localparam logic [CW-1:0] FOCAL_RST = CW'(1) << (CW / 2);

    localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    // Per-point flags that ride along after the camera transform
    typedef struct packed {
        logic          zero;
        logic          front;
        logic [CW-1:0] depth;
        logic [1:0]    neg;     // sign of u and v quotient
        logic [1:0]    numneg;  // sign of f*xc, f*yc
    } side_t;

endpackage

// File: src/pinhole_point_projection.sv
// Pinhole point projection: rigid transform, focal multiply, pipelined divide.
// Depends on ppp_pkg.
//
// Usage:
//  Input channel point_x/y/z with in_valid/in_stall; one world point per beat.
//  Output channel img_u/img_v/cam_depth/in_front/zero_depth with
//  out_valid/out_stall; one result beat per input beat, in order.
//  Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
//  write only while no point is in flight.
//  Throughput: one point per clock while out_stall is low. The pipeline
//  is the 7-stage transform/multiply front end and the 34-stage restoring
//  divider (one quotient bit per stage) plus the output register.
//  Each stage has its own valid bit; a stage loads when it is empty or the
//  stage after it moves, so bubbles close up while out_stall is high and
//  in_stall rises only once every stage holds a point.
//  Reset clears all valid bits and loads the identity pose, zero
//  translation, focal length 1.0 and a zero image center.
module pinhole_point_projection (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ppp_pkg::CW-1:0] point_x,
    input  logic [ppp_pkg::CW-1:0] point_y,
    input  logic [ppp_pkg::CW-1:0] point_z,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ppp_pkg::CW-1:0] img_u,
    output logic [ppp_pkg::CW-1:0] img_v,
    output logic [ppp_pkg::CW-1:0] cam_depth,
    output logic                   in_front,
    output logic                   zero_depth,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data
);
    import ppp_pkg::*;

    // Configuration registers
    logic [62:0]   rot_reg [0:2];
    logic [CW-1:0] trans_reg [0:2];
    logic [CW-1:0] focal_reg;
    logic [63:0]   ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0]   <= ROT0_RST;
            rot_reg[1]   <= ROT1_RST;
            rot_reg[2]   <= ROT2_RST;
            trans_reg[0] <= '0;
            trans_reg[1] <= '0;
            trans_reg[2] <= '0;
            focal_reg    <= FOCAL_RST;
            ctr_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT0:  rot_reg[0]   <= cfg_data[62:0];
                REG_ROT1:  rot_reg[1]   <= cfg_data[62:0];
                REG_ROT2:  rot_reg[2]   <= cfg_data[62:0];
                REG_TX:    trans_reg[0] <= cfg_data[CW-1:0];
                REG_TY:    trans_reg[1] <= cfg_data[CW-1:0];
                REG_TZ:    trans_reg[2] <= cfg_data[CW-1:0];
                REG_FOCAL: focal_reg    <= cfg_data[CW-1:0];
                REG_CTR:   ctr_reg      <= cfg_data;
                default:   ctr_reg      <= ctr_reg;
            endcase
        end
    end

    // Stage valids and advance chain
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE:0]   adv;

    always_comb
    begin
        adv[NSTAGE] = !out_stall;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NSTAGE-1];

    // Stage 1: nine rotation products
    logic signed [CW-1:0] pt [0:2];
    logic signed [PW-1:0] prod_reg [0:2][0:2];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= $signed(rot_reg[i][j*RW +: RW]) * pt[j];
                end
            end
        end
    end

    // Stage 2: row sums
    logic signed [SW-1:0] sum_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= SW'(prod_reg[i][0]) + SW'(prod_reg[i][1])
                            + SW'(prod_reg[i][2]);
            end
        end
    end

    // Stage 3: round half up to coordinate fraction, add translation
    logic signed [SW-1:0]   rnd [0:2];
    logic signed [CAMW-1:0] cam_reg [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = sum_reg[i] + (SW'(1) <<< (RFRAC - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                cam_reg[i] <= CAMW'($signed(rnd[i][SW-1:RFRAC]))
                            + CAMW'($signed(trans_reg[i]));
            end
        end
    end

    // Stage 4: magnitudes, depth flags, saturated depth
    logic [CAMW-1:0] mag_reg [0:2];
    side_t           side4_reg;
    side_t           side4_next;

    always_comb
    begin
        side4_next.zero  = (cam_reg[2] == '0);
        side4_next.front = $signed({cam_reg[2][CAMW-1], cam_reg[2]})
                           >= $signed({{(CAMW+1-CW){1'b0}}, focal_reg});
        if (cam_reg[2] > CAMW'(SAT_MAX))
        begin
            side4_next.depth = SAT_MAX;
        end
        else if (cam_reg[2] < CAMW'(SAT_MIN))
        begin
            side4_next.depth = SAT_MIN;
        end
        else
        begin
            side4_next.depth = cam_reg[2][CW-1:0];
        end
        for (int l = 0; l < 2; l++)
        begin
            side4_next.numneg[l] = cam_reg[l][CAMW-1] && (focal_reg != '0);
            side4_next.neg[l]    = side4_next.numneg[l] ^ cam_reg[2][CAMW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= cam_reg[i][CAMW-1] ? -cam_reg[i] : cam_reg[i];
            end
            side4_reg <= side4_next;
        end
    end

    // Stage 5: focal multiply in two partial products
    logic [CW+HALFM-1:0]      plo_reg [0:1];
    logic [CW+CAMW-HALFM-1:0] phi_reg [0:1];
    logic [CAMW-1:0]          ad5_reg;
    side_t                    side5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int l = 0; l < 2; l++)
            begin
                plo_reg[l] <= focal_reg * mag_reg[l][HALFM-1:0];
                phi_reg[l] <= focal_reg * mag_reg[l][CAMW-1:HALFM];
            end
            ad5_reg   <= mag_reg[2];
            side5_reg <= side4_reg;
        end
    end

    // Stage 6: dividend 2|n| + |zc| and divisor 2|zc|
    logic [NUMW-1:0] an [0:1];
    logic [NW-1:0]   num6_reg [0:1];
    logic [DW-1:0]   den6_reg;
    side_t           side6_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            an[l] = NUMW'(plo_reg[l]) + {phi_reg[l], {HALFM{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int l = 0; l < 2; l++)
            begin
                num6_reg[l] <= {1'b0, an[l], 1'b0} + NW'(ad5_reg);
            end
            den6_reg  <= {ad5_reg, 1'b0};
            side6_reg <= side5_reg;
        end
    end

    // Divider pipeline; index 0 is the overflow check stage
    logic [DW-1:0]   rem_reg  [0:QB][0:1];
    logic [QB-1:0]   quo_reg  [0:QB][0:1];
    logic [QB-1:0]   nlo_reg  [0:QB][0:1];
    logic [1:0]      ovf_reg  [0:QB];
    logic [DW-1:0]   den_reg  [0:QB];
    side_t           side_reg [0:QB];

    // Stage 7: quotient overflow test, remainder seed
    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int l = 0; l < 2; l++)
            begin
                ovf_reg[0][l] <= {1'b0, num6_reg[l]} >= {den6_reg, {QB{1'b0}}};
                rem_reg[0][l] <= DW'(num6_reg[l][NW-1:QB]);
                nlo_reg[0][l] <= num6_reg[l][QB-1:0];
                quo_reg[0][l] <= '0;
            end
            den_reg[0]  <= den6_reg;
            side_reg[0] <= side6_reg;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [DW:0] trial [0:1];
        logic [1:0]  take;

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l] = {rem_reg[k][l], nlo_reg[k][l][QB-1-k]};
                take[l]  = trial[l] >= {1'b0, den_reg[k]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[7+k])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[k+1][l] <= take[l] ? DW'(trial[l] - {1'b0, den_reg[k]})
                                               : DW'(trial[l]);
                    quo_reg[k+1][l] <= {quo_reg[k][l][QB-2:0], take[l]};
                    nlo_reg[k+1][l] <= nlo_reg[k][l];
                end
                ovf_reg[k+1]  <= ovf_reg[k];
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Output stage: sign, add center, saturate
    logic signed [QB+2:0]  uv_sum [0:1];
    logic [CW-1:0]         uv_next [0:1];
    logic [CW-1:0]         uv_reg [0:1];
    logic [CW-1:0]         depth_reg;
    logic                  front_reg;
    logic                  zero_reg;
    side_t                 sf;

    always_comb
    begin
        sf = side_reg[QB];
        for (int l = 0; l < 2; l++)
        begin
            uv_sum[l] = (sf.neg[l] ? -$signed({3'b0, quo_reg[QB][l]})
                                   :  $signed({3'b0, quo_reg[QB][l]}))
                      + $signed((QB+3)'(ctr_reg[32*l +: CW]));
            if (sf.zero)
            begin
                uv_next[l] = sf.numneg[l] ? SAT_MIN : SAT_MAX;
            end
            else if (ovf_reg[QB][l])
            begin
                uv_next[l] = sf.neg[l] ? SAT_MIN : SAT_MAX;
            end
            else if (uv_sum[l] > (QB+3)'(SAT_MAX))
            begin
                uv_next[l] = SAT_MAX;
            end
            else if (uv_sum[l] < (QB+3)'(SAT_MIN))
            begin
                uv_next[l] = SAT_MIN;
            end
            else
            begin
                uv_next[l] = uv_sum[l][CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NSTAGE-1])
        begin
            uv_reg[0] <= uv_next[0];
            uv_reg[1] <= uv_next[1];
            depth_reg <= sf.depth;
            front_reg <= sf.front;
            zero_reg  <= sf.zero;
        end
    end

    assign img_u      = uv_reg[0];
    assign img_v      = uv_reg[1];
    assign cam_depth  = depth_reg;
    assign in_front   = front_reg;
    assign zero_depth = zero_reg;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for pinhole_point_projection: a directed point table,
// then random poses and points, checked against an in-bench projection model.
// Depends on ppp_pkg and the pinhole_point_projection RTL.
module tb_top;
    import ppp_pkg::*;

    typedef struct packed {
        logic [CW-1:0] u;
        logic [CW-1:0] v;
        logic [CW-1:0] depth;
        logic          front;
        logic          zero;
    } proj_t;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        bit            typed;
        proj_t         want;
    } point_row_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [CW-1:0] point_x = '0;
    logic [CW-1:0] point_y = '0;
    logic [CW-1:0] point_z = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [CW-1:0] img_u;
    logic [CW-1:0] img_v;
    logic [CW-1:0] cam_depth;
    logic          in_front;
    logic          zero_depth;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [63:0]   cfg_data = '0;

    // Model copy of the pose and intrinsics
    logic [62:0]          rot_rows [3];
    logic signed [CW-1:0] trans [3];
    logic [CW-1:0]        focal;
    logic [63:0]          center;

    proj_t pending_proj [$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    quiet = 1'b0;

    pinhole_point_projection dut (.*);

    always #5 clk = ~clk;

    function automatic logic [CW-1:0] clamp(logic signed [127:0] val);
        if (val < -(128'sd1 <<< (CW - 1)))
            return SAT_MIN;
        if (val > ((128'sd1 <<< (CW - 1)) - 1))
            return SAT_MAX;
        return val[CW-1:0];
    endfunction

    // Camera transform, then focal divide with round-half-away and centering
    function automatic proj_t project(logic [CW-1:0] px, logic [CW-1:0] py,
                                      logic [CW-1:0] pz);
        longint               pt [3];
        longint               cam [3];
        longint               acc;
        longint               adepth;
        logic signed [RW-1:0] e;
        logic signed [127:0]  fw, cwide, num, an, den, q, ctr;
        logic                 neg;
        proj_t                r;
        pt[0] = longint'($signed(px));
        pt[1] = longint'($signed(py));
        pt[2] = longint'($signed(pz));
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
            begin
                e = rot_rows[i][j*RW +: RW];
                acc += longint'(e) * pt[j];
            end
            acc = (acc + (64'sd1 <<< (RFRAC - 1))) >>> RFRAC;
            cam[i] = acc + longint'(trans[i]);
        end
        fw = {96'b0, focal};
        r.zero = (cam[2] == 0);
        adepth = cam[2] < 0 ? -cam[2] : cam[2];
        for (int i = 0; i < 2; i++)
        begin
            cwide = cam[i];
            num = fw * cwide;
            if (r.zero)
                q = num < 0 ? 128'(SAT_MIN) : 128'(SAT_MAX);
            else
            begin
                neg = (num < 0) != (cam[2] < 0);
                an = num < 0 ? -num : num;
                den = adepth;
                q = (2 * an + den) / (2 * den);
                if (neg)
                    q = -q;
                ctr = {96'b0, center[i*32 +: 32]};
                q = q + ctr;
            end
            if (r.zero)
                q = num < 0 ? -(128'sd1 <<< (CW - 1)) : ((128'sd1 <<< (CW - 1)) - 1);
            if (i == 0)
                r.u = clamp(q);
            else
                r.v = clamp(q);
        end
        cwide = cam[2];
        r.depth = clamp(cwide);
        r.front = cam[2] >= longint'({32'b0, focal});
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_ROT0:  rot_rows[0] = val[62:0];
            REG_ROT1:  rot_rows[1] = val[62:0];
            REG_ROT2:  rot_rows[2] = val[62:0];
            REG_TX:    trans[0] = val[31:0];
            REG_TY:    trans[1] = val[31:0];
            REG_TZ:    trans[2] = val[31:0];
            REG_FOCAL: focal = val[31:0];
            REG_CTR:   center = val;
            default:   ;
        endcase
    endtask

    // Hold off input until the pipeline has drained
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_proj.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x <= x;
        point_y <= y;
        point_z <= z;
        do
            @(posedge clk);
        while (in_stall);
        pending_proj.insert(pending_proj.size(), project(x, y, z));
    endtask

    function automatic logic [20:0] rand_entry(int mode);
        case (mode)
            0: return 21'h100000;
            1: return 21'h0FFFFF;
            2: return 21'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return 21'($urandom);
        endcase
    endfunction

    // Random pose and intrinsics, the extremes included now and then
    task automatic random_config();
        logic [62:0] row;
        int          mode;
        logic [31:0] f;
        mode = $urandom_range(0, 4);
        for (int i = 0; i < 3; i++)
        begin
            row = '0;
            for (int j = 0; j < 3; j++)
                if (mode == 4)
                    row[j*RW +: RW] = (i == j) ? 21'h080000 : 21'h0;
                else
                    row[j*RW +: RW] = rand_entry($urandom_range(0, 3) == 0 ? mode : 2 + mode % 2);
            write_reg(REG_ROT0 + 3'(i), {1'b0, row});
        end
        for (int i = 0; i < 3; i++)
            write_reg(REG_TX + 3'(i), {32'b0, ($urandom_range(0, 2) == 0) ? 32'($urandom) :
                      32'($signed($urandom_range(0, 1 << 22)) - (1 << 21))});
        case ($urandom_range(0, 7))
            0:       f = 32'hFFFF_FFFF;
            1:       f = 32'd1;
            2:       f = 32'd0;
            3, 4:    f = 32'($urandom);
            default: f = $urandom_range(1, 1 << 22);
        endcase
        write_reg(REG_FOCAL, {32'b0, f});
        case ($urandom_range(0, 3))
            0:       write_reg(REG_CTR, 64'h0);
            1:       write_reg(REG_CTR, 64'hFFFF_FFFF_FFFF_FFFF);
            default: write_reg(REG_CTR, {32'($urandom), 32'($urandom)});
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 32'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'h0;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h8000_0000;
                    3:       return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            2, 3:    return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    // Receiver stall bursts
    initial
    begin
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= $urandom_range(0, 2) == 0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        proj_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_proj.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat u=%h v=%h", $time, img_u, img_v);
            end
            else
            begin
                want = pending_proj.pop_front();
                if (img_u !== want.u)
                begin
                    mismatches++;
                    $display("%0t: img_u expected %h actual %h", $time, want.u, img_u);
                end
                if (img_v !== want.v)
                begin
                    mismatches++;
                    $display("%0t: img_v expected %h actual %h", $time, want.v, img_v);
                end
                if (cam_depth !== want.depth)
                begin
                    mismatches++;
                    $display("%0t: cam_depth expected %h actual %h", $time, want.depth,
                             cam_depth);
                end
                if (in_front !== want.front)
                begin
                    mismatches++;
                    $display("%0t: in_front expected %b actual %b", $time, want.front,
                             in_front);
                end
                if (zero_depth !== want.zero)
                begin
                    mismatches++;
                    $display("%0t: zero_depth expected %b actual %b", $time, want.zero,
                             zero_depth);
                end
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        point_row_t rows [9];
        proj_t      want;
        rot_rows[0] = ROT0_RST;
        rot_rows[1] = ROT1_RST;
        rot_rows[2] = ROT2_RST;
        trans[0] = '0;
        trans[1] = '0;
        trans[2] = '0;
        focal = FOCAL_RST;
        center = '0;

        // origin: zero depth, both axes clamp high
        rows[0] = '{32'h0, 32'h0, 32'h0, 1'b1,
                    '{SAT_MAX, SAT_MAX, 32'h0, 1'b0, 1'b1}};
        rows[1] = '{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b1,
                    '{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b1, 1'b0}};
        // zero depth with negative x clamps u low
        rows[2] = '{32'hFFFF_0000, 32'h0, 32'h0, 1'b1,
                    '{SAT_MIN, SAT_MAX, 32'h0, 1'b0, 1'b1}};
        rows[3] = '{32'h0, 32'h0, 32'hFFFF_0000, 1'b1,
                    '{32'h0, 32'h0, 32'hFFFF_0000, 1'b0, 1'b0}};
        rows[4] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0};
        rows[5] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0};
        rows[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0, '0};
        rows[7] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0};
        rows[8] = '{32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0002, 1'b0, '0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default pose, then extreme pose, then zero focal length
        for (int pass = 0; pass < 3; pass++)
        begin
            if (pass == 1)
            begin
                drain_pipe();
                write_reg(REG_ROT0, {1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF});
                write_reg(REG_ROT1, {1'b0, 21'h100000, 21'h0FFFFF, 21'h100000});
                write_reg(REG_ROT2, {1'b0, 21'h0FFFFF, 21'h0FFFFF, 21'h100000});
                write_reg(REG_TX, 64'h0000_0000_7FFF_FFFF);
                write_reg(REG_TY, 64'h0000_0000_8000_0000);
                write_reg(REG_TZ, 64'h0000_0000_0001_0000);
                write_reg(REG_FOCAL, 64'h0000_0000_FFFF_FFFF);
                write_reg(REG_CTR, 64'hFFFF_FFFF_FFFF_FFFF);
                cfg_we <= 1'b0;
                @(posedge clk);
            end
            if (pass == 2)
            begin
                drain_pipe();
                write_reg(REG_FOCAL, 64'h0);
                write_reg(REG_CTR, 64'h0040_0000_0080_0000);
                cfg_we <= 1'b0;
                @(posedge clk);
            end
            foreach (rows[k])
            begin
                if (pass == 0 && rows[k].typed)
                begin
                    want = project(rows[k].x, rows[k].y, rows[k].z);
                    if (want != rows[k].want)
                    begin
                        mismatches++;
                        $display("%0t: table row %0d model disagrees, expected u=%h actual u=%h",
                                 $time, k, rows[k].want.u, want.u);
                    end
                end
                send_point(rows[k].x, rows[k].y, rows[k].z);
            end
        end

        // Random phases; the last runs with no idling on either side
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_pipe();
            random_config();
            if (phase == 7)
                quiet = 1'b1;
            for (int n = 0; n < 240; n++)
                send_point(rand_coord(), rand_coord(), rand_coord());
        end

        in_valid <= 1'b0;
        while (pending_proj.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
src/ppp_pkg.sv
src/pinhole_point_projection.sv
tb/sv/tb_top.sv
